>>> sv/fewd_pkg.sv
// Shared types, constants and register codes for the frame energy wake/sleep detector.
package fewd_pkg;

  // Default longest frame, in samples
  localparam int MAX_FRAME_SAMPLES_DEF = 1024;

  // Fixed widths of the datapath
  localparam int SMP_W      = 16;  // PCM sample
  localparam int SQ_W       = 32;  // square of a sample magnitude
  localparam int RMS_W      = 16;  // frame rms
  localparam int RAD_W      = 32;  // radicand of the square root
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int SQ_ALU_W   = 19;  // partial remainder width of the root recurrence
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_LEVEL   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_LEVEL  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_FRAMES  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_FRAMES = 8'd3;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] WAKE_LEVEL_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] SLEEP_LEVEL_RST  = 16'd300;
  localparam logic [CFG_W-1:0] WAKE_FRAMES_RST  = 16'd3;
  localparam logic [CFG_W-1:0] SLEEP_FRAMES_RST = 16'd50;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_WAKE  = 2'd1,
    EV_SLEEP = 2'd2
  } event_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last_in_frame;
  } in_item_t;

  typedef struct packed {
    event_t             event_res;
    logic [RMS_W-1:0]   frame_rms;
    logic               is_active;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] wake_level;
    logic [CFG_W-1:0] sleep_level;
    logic [CFG_W-1:0] wake_frames;
    logic [CFG_W-1:0] sleep_frames;
  } cfg_t;

  // Frame result handed from the arithmetic core to the top level
  typedef struct packed {
    logic             done;
    logic [RMS_W-1:0] rms;
  } frame_result_t;

  // Decision of the wake/sleep state machine for one frame
  typedef struct packed {
    event_t event_res;
    logic   is_active;
  } verdict_t;

endpackage

>>> sv/fewd_cmpsub.sv
// Shared compare-and-subtract unit used by the divider and the square root.
module fewd_cmpsub #(
  parameter int W = 19
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] wide;

  // Borrow out of a - b tells whether a >= b
  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[W];
  assign diff = wide[W-1:0];

endmodule

>>> sv/fewd_core.sv
// Sample accumulator, frame divider and square root around one compare-subtract unit.
module fewd_core import fewd_pkg::*; #(
  parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  input  logic          slot_free,
  output frame_result_t result
);

  localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W  = SQ_W - 2 + CNT_W;
  localparam int ALU_W  = (CNT_W + 1 > SQ_ALU_W) ? CNT_W + 1 : SQ_ALU_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SQRT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t             state;
  logic [SQ_W-1:0]    prod;
  logic               last_flag;
  logic [SUM_W-1:0]   square_sum;
  logic [CNT_W-1:0]   sample_total;
  logic [SUM_W-1:0]   work;
  logic [CNT_W-1:0]   divisor;
  logic [ALU_W-1:0]   rem;
  logic [RAD_W-1:0]   rad;
  logic [RMS_W-1:0]   root;
  logic [STEP_W-1:0]  step;

  logic [SMP_W-1:0]   raw;
  logic [SMP_W-1:0]   mag;
  logic               room;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]   total_next;
  logic [ALU_W-1:0]   div_part;
  logic [ALU_W-1:0]   sqrt_part;
  logic [ALU_W-1:0]   alu_a;
  logic [ALU_W-1:0]   alu_b;
  logic               alu_ge;
  logic [ALU_W-1:0]   alu_diff;
  logic [SUM_W-1:0]   quo_full;

  assign in_ready = (state == S_IDLE);

  // Magnitude of the incoming sample; the most negative code maps to 32768
  assign raw = in_data.sample;
  assign mag = raw[SMP_W-1] ? (~raw + SMP_W'(1)) : raw;

  // Accumulate only while the frame has room
  assign room       = sample_total < CNT_W'(MAX_FRAME_SAMPLES);
  assign sum_next   = room ? square_sum + SUM_W'(prod) : square_sum;
  assign total_next = room ? sample_total + CNT_W'(1) : sample_total;

  // Operand selection for the shared unit
  assign div_part  = {rem[ALU_W-2:0], work[SUM_W-1]};
  assign sqrt_part = {rem[ALU_W-3:0], rad[RAD_W-1:RAD_W-2]};
  assign alu_a     = (state == S_DIV) ? div_part : sqrt_part;
  assign alu_b     = (state == S_DIV) ? ALU_W'(divisor) : ALU_W'({root, 2'b01});

  fewd_cmpsub #(.W(ALU_W)) u_cmpsub (
    .a    (alu_a),
    .b    (alu_b),
    .ge   (alu_ge),
    .diff (alu_diff)
  );

  assign quo_full = {work[SUM_W-2:0], alu_ge};

  assign result.done = (state == S_DONE);
  assign result.rms  = root;

  // Sequencer: square on accept, add, then divide and root at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      square_sum   <= '0;
      sample_total <= '0;
      step         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            prod      <= SQ_W'(mag) * SQ_W'(mag);
            last_flag <= in_data.last_in_frame;
            state     <= S_ADD;
          end
        end
        S_ADD: begin
          if (last_flag) begin
            work         <= sum_next;
            divisor      <= total_next;
            rem          <= '0;
            step         <= '0;
            square_sum   <= '0;
            sample_total <= '0;
            state        <= S_DIV;
          end else begin
            square_sum   <= sum_next;
            sample_total <= total_next;
            state        <= S_IDLE;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle, shifted into the dividend register
          work <= quo_full;
          if (step == STEP_W'(SUM_W - 1)) begin
            rad   <= RAD_W'(quo_full);
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= S_SQRT;
          end else begin
            rem  <= alu_ge ? alu_diff : div_part;
            step <= step + STEP_W'(1);
          end
        end
        S_SQRT: begin
          // One root bit per cycle from two radicand bits
          rem  <= alu_ge ? alu_diff : sqrt_part;
          root <= {root[RMS_W-2:0], alu_ge};
          rad  <= {rad[RAD_W-3:0], 2'b00};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/fewd_hyst.sv
// Wake/sleep hysteresis state machine driven by one rms value per frame.
module fewd_hyst import fewd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             update,
  input  logic [RMS_W-1:0] rms,
  input  cfg_t             cfg,
  output verdict_t         verdict
);

  logic             awake;
  logic [CFG_W-1:0] loud_run;
  logic [CFG_W-1:0] quiet_run;

  logic             awake_next;
  logic [CFG_W-1:0] loud_run_next;
  logic [CFG_W-1:0] quiet_run_next;
  logic [CFG_W-1:0] loud_inc;
  logic [CFG_W-1:0] quiet_inc;
  event_t           ev;

  // Saturating increments
  assign loud_inc  = (loud_run == '1) ? loud_run : loud_run + CFG_W'(1);
  assign quiet_inc = (quiet_run == '1) ? quiet_run : quiet_run + CFG_W'(1);

  // Count loud frames while idle, quiet frames while awake
  always_comb begin
    awake_next     = awake;
    loud_run_next  = loud_run;
    quiet_run_next = quiet_run;
    ev             = EV_NONE;
    if (!awake) begin
      if (rms > cfg.wake_level) begin
        if (loud_inc >= cfg.wake_frames) begin
          awake_next     = 1'b1;
          loud_run_next  = '0;
          quiet_run_next = '0;
          ev             = EV_WAKE;
        end else begin
          loud_run_next = loud_inc;
        end
      end else if (loud_run != '0) begin
        loud_run_next = loud_run - CFG_W'(1);
      end
    end else begin
      if (rms < cfg.sleep_level) begin
        if (quiet_inc >= cfg.sleep_frames) begin
          awake_next     = 1'b0;
          loud_run_next  = '0;
          quiet_run_next = '0;
          ev             = EV_SLEEP;
        end else begin
          quiet_run_next = quiet_inc;
        end
      end else if (quiet_run != '0) begin
        quiet_run_next = quiet_run - CFG_W'(1);
      end
    end
  end

  assign verdict.event_res = ev;
  assign verdict.is_active = awake_next;

  // Commit on each finished frame
  always_ff @(posedge clk) begin
    if (rst) begin
      awake     <= 1'b0;
      loud_run  <= '0;
      quiet_run <= '0;
    end else if (update) begin
      awake     <= awake_next;
      loud_run  <= loud_run_next;
      quiet_run <= quiet_run_next;
    end
  end

endmodule

>>> sv/frame_energy_wake_sleep_detector.sv
// Frame energy wake/sleep detector: a sample that does not close a frame is squared on
// accept, then added; a closing sample is squared and added, then goes through a
// bit-serial divide of SUM_W = 30 + clog2(MAX_FRAME_SAMPLES + 1) quotient bits and a
// bit-serial square root of 16 root bits, both run on one shared compare-subtract
// unit. in_ready is low while a sample is in work. The result is held in an output
// register, so the next frame's samples are taken while it waits; a frame end waits
// only if the previous result is still not taken.
// Configuration writes are taken at any time and apply from the next frame end.
module frame_energy_wake_sleep_detector import fewd_pkg::*; #(
  parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t          cfg;
  frame_result_t result;
  verdict_t      verdict;
  logic          slot_free;
  logic          load;

  assign cfg_ready = 1'b1;

  // Decode register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wake_level   <= WAKE_LEVEL_RST;
      cfg.sleep_level  <= SLEEP_LEVEL_RST;
      cfg.wake_frames  <= WAKE_FRAMES_RST;
      cfg.sleep_frames <= SLEEP_FRAMES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WAKE_LEVEL:   cfg.wake_level   <= cfg_data;
        REG_SLEEP_LEVEL:  cfg.sleep_level  <= cfg_data;
        REG_WAKE_FRAMES:  cfg.wake_frames  <= cfg_data;
        REG_SLEEP_FRAMES: cfg.sleep_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  fewd_core #(.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .slot_free (slot_free),
    .result    (result)
  );

  assign slot_free = !out_valid || out_ready;
  assign load      = result.done && slot_free;

  fewd_hyst u_hyst (
    .clk     (clk),
    .rst     (rst),
    .update  (load),
    .rms     (result.rms),
    .cfg     (cfg),
    .verdict (verdict)
  );

  // Output register: hold the transaction until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.event_res <= verdict.event_res;
      out_data.frame_rms <= result.rms;
      out_data.is_active <= verdict.is_active;
    end
  end

endmodule

>>> tb/frame_energy_wake_sleep_detector_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame energy wake/sleep detector.
module frame_energy_wake_sleep_detector_tb import fewd_pkg::*; ();

  localparam int CLK_HALF      = 4;
  localparam int FRAME_MAX     = MAX_FRAME_SAMPLES_DEF;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int MAG_MAX       = 32768;

  // Indexes outside the register map, written to check that they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  typedef enum int {FK_LOUD, FK_QUIET, FK_NEAR, FK_NOISE} frame_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predicted detector state and register copy
  cfg_t            cfg_m;
  longint unsigned energy_sum;
  int unsigned     energy_count;
  int unsigned     loud_cnt;
  int unsigned     quiet_cnt;
  logic            awake_m;

  out_item_t   verdict_q[$];
  int          errors = 0;
  bit          idle_en = 1'b1;
  int          stall_left = 0;
  int unsigned cycles = 0;

  frame_energy_wake_sleep_detector dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 8);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest predicted verdict
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual event %0d rms %0d active %0d",
                 $time, out_data.event_res, out_data.frame_rms, out_data.is_active);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.event_res !== want.event_res) begin
          errors++;
          $display("%0t: event_res expected %0d actual %0d",
                   $time, want.event_res, out_data.event_res);
        end
        if (out_data.frame_rms !== want.frame_rms) begin
          errors++;
          $display("%0t: frame_rms expected %0d actual %0d",
                   $time, want.frame_rms, out_data.frame_rms);
        end
        if (out_data.is_active !== want.is_active) begin
          errors++;
          $display("%0t: is_active expected %0d actual %0d",
                   $time, want.is_active, out_data.is_active);
        end
      end
    end
  end

  // Integer square root, one result bit per trial from the top
  function automatic logic [RMS_W-1:0] int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = RMS_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[RMS_W-1:0];
  endfunction

  // Accumulate one sample; on a frame end push the expected verdict
  function automatic void predict_sample(logic signed [SMP_W-1:0] s, logic last);
    int              m;
    longint unsigned mean;
    out_item_t       v;
    if (energy_count < FRAME_MAX) begin
      m = s;
      if (m < 0) m = -m;
      energy_sum += longint'(m) * longint'(m);
      energy_count++;
    end
    if (!last) return;
    mean = (energy_count != 0) ? energy_sum / energy_count : 0;
    v.frame_rms = int_sqrt(mean);
    v.event_res = EV_NONE;
    energy_sum = 0;
    energy_count = 0;
    if (!awake_m) begin
      if (v.frame_rms > cfg_m.wake_level) begin
        if (loud_cnt < 16'hFFFF) loud_cnt++;
        if (loud_cnt >= cfg_m.wake_frames) begin
          awake_m = 1'b1;
          loud_cnt = 0;
          quiet_cnt = 0;
          v.event_res = EV_WAKE;
        end
      end else if (loud_cnt > 0) begin
        loud_cnt--;
      end
    end else begin
      if (v.frame_rms < cfg_m.sleep_level) begin
        if (quiet_cnt < 16'hFFFF) quiet_cnt++;
        if (quiet_cnt >= cfg_m.sleep_frames) begin
          awake_m = 1'b0;
          quiet_cnt = 0;
          loud_cnt = 0;
          v.event_res = EV_SLEEP;
        end
      end else if (quiet_cnt > 0) begin
        quiet_cnt--;
      end
    end
    v.is_active = awake_m;
    verdict_q.push_back(v);
  endfunction

  // Send one sample transaction, with an occasional idle burst ahead of it
  task automatic send_sample(input logic signed [SMP_W-1:0] s, input logic last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample: s, last_in_frame: last};
    do @(posedge clk); while (!in_ready);
    predict_sample(s, last);
  endtask

  // Hold off the sender until every verdict has come and the block is quiet
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WAKE_LEVEL:   cfg_m.wake_level = val;
      REG_SLEEP_LEVEL:  cfg_m.sleep_level = val;
      REG_WAKE_FRAMES:  cfg_m.wake_frames = val;
      REG_SLEEP_FRAMES: cfg_m.sleep_frames = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] wt, input logic [CFG_W-1:0] st,
                            input logic [CFG_W-1:0] wh, input logic [CFG_W-1:0] sh);
    wait_drain();
    write_reg(REG_WAKE_LEVEL, wt);
    write_reg(REG_SLEEP_LEVEL, st);
    write_reg(REG_WAKE_FRAMES, wh);
    write_reg(REG_SLEEP_FRAMES, sh);
  endtask

  // Random sample with magnitude in [lo, hi]; full scale is negative only
  function automatic logic signed [SMP_W-1:0] pick_sample(int lo, int hi);
    int m;
    m = $urandom_range(hi, lo);
    if (m > 32767 || $urandom_range(0, 1) == 1) m = -m;
    return m[SMP_W-1:0];
  endfunction

  // Send a frame whose rms falls in the band that the kind asks for
  task automatic send_frame(input frame_kind_t kind, input int len);
    int wt;
    int st;
    int c;
    int lo;
    int hi;
    wt = cfg_m.wake_level;
    st = cfg_m.sleep_level;
    case (kind)
      FK_LOUD: begin
        lo = (wt >= MAG_MAX) ? MAG_MAX : wt + 1;
        hi = MAG_MAX;
      end
      FK_QUIET: begin
        lo = 0;
        hi = (st == 0) ? 0 : ((st - 1 > MAG_MAX) ? MAG_MAX : st - 1);
      end
      FK_NEAR: begin
        c  = ($urandom_range(0, 1) == 1) ? wt : st;
        if (c > MAG_MAX) c = MAG_MAX;
        lo = (c < 3) ? 0 : c - 3;
        hi = (c + 3 > MAG_MAX) ? MAG_MAX : c + 3;
      end
      default: begin
        lo = 0;
        hi = MAG_MAX;
      end
    endcase
    for (int i = 0; i < len; i++) send_sample(pick_sample(lo, hi), i == len - 1);
  endtask

  // Run random frames, mostly pushing the state machine toward its next event
  task automatic run_frames(input int target);
    int          sent;
    int          len;
    int          r;
    frame_kind_t k;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      r = $urandom_range(0, 9);
      if (r < 6)       k = awake_m ? FK_QUIET : FK_LOUD;
      else if (r < 8)  k = FK_NEAR;
      else if (r == 8) k = awake_m ? FK_LOUD : FK_QUIET;
      else             k = FK_NOISE;
      send_frame(k, len);
      sent += len;
      if ($urandom_range(0, 39) == 0) wait_drain();
    end
  endtask

  // Reset defaults: full-scale samples and three loud frames to wake
  task automatic test_defaults();
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(-16'sh2AAB, 1'b1);
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd1001, 1'b1);
    send_sample(16'sd300, 1'b1);
    send_sample(16'sd299, 1'b1);
  endtask

  // Zero hold fires on the first qualifying frame; unmapped indexes are ignored
  task automatic test_zero_hold();
    set_config(16'd0, 16'd32768, 16'd0, 16'd0);
    write_reg(REG_UNUSED_LO, 16'd5);
    write_reg(REG_UNUSED_HI, 16'hFFFF);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b1);
  endtask

  // A frame past the longest length; samples beyond it are dropped
  task automatic test_overlong_frame();
    set_config(16'd1000, 16'd300, 16'd1, 16'd1);
    send_frame(FK_NOISE, FRAME_MAX + 5);
    send_frame(FK_QUIET, 3);
  endtask

  // Random frames over several register settings, extremes first
  task automatic test_random_phases();
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(16'd1000, 16'd300, 16'd2, 16'd3);
        1: set_config(16'd0, 16'd32768, 16'd1, 16'd1);
        2: set_config(16'd32768, 16'd0, 16'hFFFF, 16'hFFFF);
        3: set_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        default: set_config(CFG_W'($urandom_range(0, MAG_MAX)),
                            CFG_W'($urandom_range(0, MAG_MAX)),
                            CFG_W'($urandom_range(0, 5)), CFG_W'($urandom_range(0, 5)));
      endcase
      // Drop all idling for the last phase
      if (p == 6) idle_en = 1'b0;
      run_frames(20);
    end
  endtask

  initial begin
    cfg_m.wake_level   = WAKE_LEVEL_RST;
    cfg_m.sleep_level  = SLEEP_LEVEL_RST;
    cfg_m.wake_frames  = WAKE_FRAMES_RST;
    cfg_m.sleep_frames = SLEEP_FRAMES_RST;
    energy_sum   = 0;
    energy_count = 0;
    loud_cnt     = 0;
    quiet_cnt    = 0;
    awake_m      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_zero_hold();
    test_overlong_frame();
    test_random_phases();
    wait_drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> frame_energy_wake_sleep_detector.f
sv/fewd_pkg.sv
sv/fewd_cmpsub.sv
sv/fewd_core.sv
sv/fewd_hyst.sv
sv/frame_energy_wake_sleep_detector.sv
tb/frame_energy_wake_sleep_detector_tb.sv
